// ----- design/fcalc_pkg.sv -----
// Shared types, key codes and constants of the four-function calculator keypad.
// Depends on nothing; fcalc_dp, fcalc_ctrl and the top use it by scoped names.
`default_nettype none

package fcalc_pkg;

  localparam logic [2:0] KEY_DIGIT  = 3'd0;
  localparam logic [2:0] KEY_POINT  = 3'd1;
  localparam logic [2:0] KEY_CLEAR  = 3'd2;
  localparam logic [2:0] KEY_ADD    = 3'd3;
  localparam logic [2:0] KEY_SUB    = 3'd4;
  localparam logic [2:0] KEY_MUL    = 3'd5;
  localparam logic [2:0] KEY_DIV    = 3'd6;
  localparam logic [2:0] KEY_EQUALS = 3'd7;

  localparam logic [2:0] OP_NONE = 3'd0;
  localparam logic [2:0] OP_ADD  = 3'd1;
  localparam logic [2:0] OP_SUB  = 3'd2;
  localparam logic [2:0] OP_MUL  = 3'd3;
  localparam logic [2:0] OP_DIV  = 3'd4;

  localparam logic [1:0] SHOW_ENTRY = 2'd0;
  localparam logic [1:0] SHOW_ACC   = 2'd1;
  localparam logic [1:0] SHOW_ZERO  = 2'd2;

  localparam int ENTRY_W = 54;
  localparam logic [ENTRY_W-1:0] ENTRY_MAX = '1;

  // Operand pairs for the shared multiplier.
  typedef enum logic [1:0] {
    MSEL_ACC_ENTRY,
    MSEL_ACC_SCALE,
    MSEL_TYPED_POW
  } mul_sel_t;

  typedef struct packed {
    logic       clear_flags;
    logic       append;
    logic [3:0] digit;
    logic       set_point;
    logic       clear_all;
    logic       clear_entry;
    logic       add;
    logic       sub;
    logic       mul_start;
    mul_sel_t   mul_sel;
    logic       div_start;
    logic       div_by_entry;
    logic       write_quot;
    logic       scale_write;
    logic       load_out;
    logic [1:0] display;
    logic       ignored;
    logic       div_zero;
  } fcalc_cmd_t;

  typedef struct packed {
    logic       mul_busy;
    logic       div_busy;
    logic [3:0] digit_count;
    logic [3:0] fraction_count;
    logic       point_seen;
    logic       entry_zero;
  } fcalc_status_t;

  function automatic logic [63:0] fcalc_pow10(input logic [4:0] n);
    logic [63:0] p;
    case (n)
      5'd0:    p = 64'd1;
      5'd1:    p = 64'd10;
      5'd2:    p = 64'd100;
      5'd3:    p = 64'd1000;
      5'd4:    p = 64'd10000;
      5'd5:    p = 64'd100000;
      5'd6:    p = 64'd1000000;
      5'd7:    p = 64'd10000000;
      5'd8:    p = 64'd100000000;
      5'd9:    p = 64'd1000000000;
      5'd10:   p = 64'd10000000000;
      5'd11:   p = 64'd100000000000;
      5'd12:   p = 64'd1000000000000;
      default: p = 64'd1;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

// ----- design/fcalc_mul.sv -----
// Iterative 64 x 64 unsigned shift-and-add multiplier, one bit per cycle.
// Depends on nothing outside this file.
`default_nettype none

module fcalc_mul (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [63:0]  a,
  input  wire logic [63:0]  b,
  output logic              busy,
  output logic [127:0]      product
);

  logic [63:0] mcand;
  logic [63:0] hi;
  logic [63:0] lo;
  logic [5:0]  count;
  logic [64:0] sum;

  assign sum     = {1'b0, hi} + (lo[0] ? {1'b0, mcand} : 65'd0);
  assign product = {hi, lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= '1;
      mcand <= a;
      hi    <= '0;
      lo    <= b;
    end else if (busy) begin
      hi    <= sum[64:1];
      lo    <= {sum[0], lo[63:1]};
      count <= count - 6'd1;
      if (count == 6'd0) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/fcalc_div.sv -----
// Restoring 128 / 64 unsigned divider, one quotient bit per cycle.
// The divisor must be nonzero and below 2^63. Depends on nothing outside this file.
`default_nettype none

module fcalc_div (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [127:0] dividend,
  input  wire logic [63:0]  divisor,
  output logic              busy,
  output logic [127:0]      quotient
);

  logic [63:0] d;
  logic [63:0] r;
  logic [63:0] r2;
  logic        ge;
  logic [6:0]  count;

  assign r2       = {r[62:0], quotient[127]};
  assign ge       = r2 >= d;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy     <= 1'b1;
      count    <= '1;
      d        <= divisor;
      r        <= '0;
      quotient <= dividend;
    end else if (busy) begin
      r        <= ge ? r2 - d : r2;
      quotient <= {quotient[126:0], ge};
      count    <= count - 7'd1;
      if (count == 7'd0) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/fcalc_dp.sv -----
// Datapath: entry, accumulator, saturating add and subtract, the shared
// multiplier and divider, and the output register. Depends on fcalc_pkg,
// fcalc_mul and fcalc_div.
`default_nettype none

module fcalc_dp #(
  parameter int ENTRY_DIGITS    = 8,
  parameter int FRACTION_DIGITS = 8
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire fcalc_pkg::fcalc_cmd_t     cmd,
  output fcalc_pkg::fcalc_status_t       status,
  output logic signed [63:0]             accumulator_value,
  output logic [fcalc_pkg::ENTRY_W-1:0]  entry_value,
  output logic [3:0]                     entry_digit_count,
  output logic                           entry_has_point,
  output logic [1:0]                     display_select,
  output logic                           key_ignored,
  output logic                           overflow,
  output logic                           divide_by_zero
);

  // 10^n < 16^n, so four bits per digit always hold the typed value.
  localparam int TW = 4 * ENTRY_DIGITS;
  localparam logic [63:0] SCALE = fcalc_pkg::fcalc_pow10(5'(FRACTION_DIGITS));
  localparam logic [63:0] S_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] S_MIN = 64'h8000_0000_0000_0000;

  logic signed [63:0]            accumulator;
  logic [TW-1:0]                 typed;
  logic [3:0]                    digit_count;
  logic [3:0]                    fraction_count;
  logic                          point_seen;
  logic [fcalc_pkg::ENTRY_W-1:0] entry_scaled;
  logic                          neg;
  logic                          ovf;

  logic [63:0]  mag;
  logic [63:0]  mul_a;
  logic [63:0]  mul_b;
  logic         mul_busy;
  logic [127:0] product;
  logic [63:0]  divisor;
  logic         div_busy;
  logic [127:0] quotient;
  logic [64:0]  sum;
  logic [64:0]  diff;
  logic [63:0]  q_limit;
  logic         q_sat;
  logic [3:0]   pow_index;

  assign mag       = accumulator[63] ? 64'(-accumulator) : 64'(accumulator);
  assign pow_index = 4'(FRACTION_DIGITS) - fraction_count;

  always_comb begin
    case (cmd.mul_sel)
      fcalc_pkg::MSEL_ACC_ENTRY: begin
        mul_a = mag;
        mul_b = 64'(entry_scaled);
      end
      fcalc_pkg::MSEL_ACC_SCALE: begin
        mul_a = mag;
        mul_b = SCALE;
      end
      default: begin
        mul_a = 64'(typed);
        mul_b = fcalc_pkg::fcalc_pow10({1'b0, pow_index});
      end
    endcase
  end

  assign divisor = cmd.div_by_entry ? 64'(entry_scaled) : SCALE;

  fcalc_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .busy    (mul_busy),
    .product (product)
  );

  fcalc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (product),
    .divisor  (divisor),
    .busy     (div_busy),
    .quotient (quotient)
  );

  assign sum     = {accumulator[63], accumulator} + 65'(entry_scaled);
  assign diff    = {accumulator[63], accumulator} - 65'(entry_scaled);
  assign q_limit = neg ? S_MIN : S_MAX;
  assign q_sat   = (quotient[127:64] != 64'd0) || (quotient[63:0] > q_limit);

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator    <= '0;
      typed          <= '0;
      digit_count    <= '0;
      fraction_count <= '0;
      point_seen     <= 1'b0;
      entry_scaled   <= '0;
      neg            <= 1'b0;
      ovf            <= 1'b0;
    end else begin
      if (cmd.clear_flags) begin
        ovf <= 1'b0;
      end
      if (cmd.mul_start && cmd.mul_sel != fcalc_pkg::MSEL_TYPED_POW) begin
        neg <= accumulator[63];
      end
      if (cmd.append) begin
        typed       <= TW'({typed, 3'b000} + {typed, 1'b0} + TW'(cmd.digit));
        digit_count <= digit_count + 4'd1;
        if (point_seen) begin
          fraction_count <= fraction_count + 4'd1;
        end
      end
      if (cmd.set_point) begin
        point_seen <= 1'b1;
      end
      if (cmd.clear_all) begin
        accumulator <= '0;
      end
      if (cmd.clear_all || cmd.clear_entry) begin
        typed          <= '0;
        digit_count    <= '0;
        fraction_count <= '0;
        point_seen     <= 1'b0;
      end
      if (cmd.add) begin
        if (!sum[64] && sum[63]) begin
          accumulator <= S_MAX;
          ovf         <= 1'b1;
        end else begin
          accumulator <= sum[63:0];
        end
      end
      if (cmd.sub) begin
        if (diff[64] && !diff[63]) begin
          accumulator <= S_MIN;
          ovf         <= 1'b1;
        end else begin
          accumulator <= diff[63:0];
        end
      end
      if (cmd.write_quot) begin
        if (q_sat) begin
          accumulator <= q_limit;
          ovf         <= 1'b1;
        end else begin
          accumulator <= neg ? -quotient[63:0] : quotient[63:0];
        end
      end
      if (cmd.scale_write) begin
        entry_scaled <= (product[127:fcalc_pkg::ENTRY_W] != '0) ? fcalc_pkg::ENTRY_MAX
                                                               : product[fcalc_pkg::ENTRY_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      accumulator_value <= accumulator;
      entry_value       <= entry_scaled;
      entry_digit_count <= digit_count;
      entry_has_point   <= point_seen;
      display_select    <= cmd.display;
      key_ignored       <= cmd.ignored;
      overflow          <= ovf;
      divide_by_zero    <= cmd.div_zero;
    end
  end

  always_comb begin
    status.mul_busy       = mul_busy;
    status.div_busy       = div_busy;
    status.digit_count    = digit_count;
    status.fraction_count = fraction_count;
    status.point_seen     = point_seen;
    status.entry_zero     = (entry_scaled == '0);
  end

endmodule

`default_nettype wire

// ----- design/fcalc_ctrl.sv -----
// Controller: key decode, pending operator and chain flag, sequencing of the
// multiplier and divider, and the output handshake. Depends on fcalc_pkg.
`default_nettype none

module fcalc_ctrl #(
  parameter int ENTRY_DIGITS    = 8,
  parameter int FRACTION_DIGITS = 8
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [2:0]               action,
  input  wire logic [3:0]               digit,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  input  wire fcalc_pkg::fcalc_status_t status,
  output fcalc_pkg::fcalc_cmd_t         cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_MUL_WAIT,
    S_DIV_WAIT,
    S_SCALE,
    S_SCALE_WAIT,
    S_OUT
  } state_t;

  state_t     state;
  logic [2:0] key;
  logic [3:0] key_digit;
  logic [2:0] pending;
  logic       chain;
  logic [2:0] op;
  logic [1:0] display;
  logic       ignored;
  logic       div_zero;

  logic       accept;
  logic       out_free;
  logic       digit_bad;
  logic [2:0] op_now;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  assign digit_bad = (key_digit > 4'd9) || (status.digit_count >= 4'(ENTRY_DIGITS)) ||
                     (status.point_seen && status.fraction_count >= 4'(FRACTION_DIGITS));
  // Equals and chained operator keys apply the pending operator; the first
  // operator key of a chain adds the entry.
  assign op_now = (key == fcalc_pkg::KEY_EQUALS || chain) ? pending : fcalc_pkg::OP_ADD;

  always_comb begin
    cmd              = '0;
    cmd.digit        = key_digit;
    cmd.mul_sel      = fcalc_pkg::MSEL_TYPED_POW;
    cmd.div_by_entry = (op == fcalc_pkg::OP_DIV);
    cmd.display      = display;
    cmd.ignored      = ignored;
    cmd.div_zero     = div_zero;
    case (state)
      S_DECODE: begin
        cmd.clear_flags = 1'b1;
        case (key)
          fcalc_pkg::KEY_DIGIT: cmd.append    = !digit_bad;
          fcalc_pkg::KEY_POINT: cmd.set_point = !status.point_seen;
          fcalc_pkg::KEY_CLEAR: cmd.clear_all = 1'b1;
          default: begin
            cmd.clear_entry = 1'b1;
            case (op_now)
              fcalc_pkg::OP_ADD: cmd.add = 1'b1;
              fcalc_pkg::OP_SUB: cmd.sub = 1'b1;
              fcalc_pkg::OP_MUL: begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = fcalc_pkg::MSEL_ACC_ENTRY;
              end
              fcalc_pkg::OP_DIV: begin
                cmd.mul_start = !status.entry_zero;
                cmd.mul_sel   = fcalc_pkg::MSEL_ACC_SCALE;
              end
              default: ;
            endcase
          end
        endcase
      end
      S_MUL_WAIT:   cmd.div_start   = !status.mul_busy;
      S_DIV_WAIT:   cmd.write_quot  = !status.div_busy;
      S_SCALE:      cmd.mul_start   = 1'b1;
      S_SCALE_WAIT: cmd.scale_write = !status.mul_busy;
      S_OUT:        cmd.load_out    = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pending   <= fcalc_pkg::OP_NONE;
      chain     <= 1'b0;
      out_valid <= 1'b0;
      op        <= fcalc_pkg::OP_NONE;
      display   <= fcalc_pkg::SHOW_ENTRY;
      ignored   <= 1'b0;
      div_zero  <= 1'b0;
      key       <= fcalc_pkg::KEY_DIGIT;
      key_digit <= '0;
    end else begin
      // A new beat may replace the one taken at this same edge.
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            key       <= action;
            key_digit <= digit;
            display   <= fcalc_pkg::SHOW_ENTRY;
            ignored   <= 1'b0;
            div_zero  <= 1'b0;
            state     <= S_DECODE;
          end
        end
        S_DECODE: begin
          state <= S_SCALE;
          op    <= op_now;
          case (key)
            fcalc_pkg::KEY_DIGIT: ignored <= digit_bad;
            fcalc_pkg::KEY_POINT: ignored <= status.point_seen;
            fcalc_pkg::KEY_CLEAR: display <= fcalc_pkg::SHOW_ZERO;
            default: begin
              if (key == fcalc_pkg::KEY_EQUALS) begin
                chain   <= 1'b0;
                display <= fcalc_pkg::SHOW_ACC;
              end else begin
                pending <= key - 3'd2;
                chain   <= 1'b1;
                display <= chain ? fcalc_pkg::SHOW_ACC : fcalc_pkg::SHOW_ZERO;
              end
              if (op_now == fcalc_pkg::OP_MUL) begin
                state <= S_MUL_WAIT;
              end else if (op_now == fcalc_pkg::OP_DIV) begin
                if (status.entry_zero) begin
                  div_zero <= 1'b1;
                end else begin
                  state <= S_MUL_WAIT;
                end
              end
            end
          endcase
        end
        S_MUL_WAIT: begin
          if (!status.mul_busy) begin
            state <= S_DIV_WAIT;
          end
        end
        S_DIV_WAIT: begin
          if (!status.div_busy) begin
            state <= S_SCALE;
          end
        end
        S_SCALE: state <= S_SCALE_WAIT;
        S_SCALE_WAIT: begin
          if (!status.mul_busy) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_units_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(status.mul_busy && status.div_busy))
    else $error("multiplier and divider busy together");

  a_accept_decodes: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_DECODE)
    else $error("accepted key not decoded");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> out_free)
    else $error("result loaded over a waiting beat");

  a_chain_set: assert property (@(posedge clk) disable iff (rst)
    (state == S_DECODE && key != fcalc_pkg::KEY_EQUALS && key != fcalc_pkg::KEY_DIGIT &&
     key != fcalc_pkg::KEY_POINT && key != fcalc_pkg::KEY_CLEAR) |=> chain)
    else $error("operator key left chain inactive");

  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !status.mul_busy && !status.div_busy)
    else $error("divider started while a unit is busy");

endmodule

`default_nettype wire

// ----- design/four_function_calculator_keypad.sv -----
// Top level of the four-function calculator keypad: controller plus datapath.
// Depends on fcalc_pkg, fcalc_ctrl and fcalc_dp.
//
//   Channel  Direction  Handshake            Beat contents
//   key      in         in_valid / in_stall  action, digit
//   result   out        out_valid/out_stall  accumulator_value, entry_value,
//                                            entry_digit_count, entry_has_point,
//                                            display_select, key_ignored,
//                                            overflow, divide_by_zero
//
// One key is worked on at a time. A key that applies no multiply or divide
// (digit, point, clear, or an operator or equals key applying add, subtract,
// nothing, or meeting a zero divisor) has its result loaded once the bit-serial
// multiplier has rescaled the typed entry. A key that applies multiply or
// divide first runs a multiply and then a restoring divide ahead of that
// rescale. The next key can be accepted at the edge after the result is
// loaded.
// Reset (rst, synchronous) zeroes the accumulator, entry, pending operator
// and chain flag. A finished result waits in the output register while the
// next key is accepted; only a second result stalls on out_stall.
`default_nettype none

module four_function_calculator_keypad #(
  parameter int ENTRY_DIGITS    = 8,
  parameter int FRACTION_DIGITS = 8
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [2:0]               action,
  input  wire logic [3:0]               digit,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic signed [63:0]            accumulator_value,
  output logic [fcalc_pkg::ENTRY_W-1:0] entry_value,
  output logic [3:0]                    entry_digit_count,
  output logic                          entry_has_point,
  output logic [1:0]                    display_select,
  output logic                          key_ignored,
  output logic                          overflow,
  output logic                          divide_by_zero
);

  // Commands flow from the controller to the datapath; status flows back.
  fcalc_pkg::fcalc_cmd_t    cmd;
  fcalc_pkg::fcalc_status_t status;

  // The controller owns both handshakes, key decode, the pending operator
  // and the chain flag.
  fcalc_ctrl #(
    .ENTRY_DIGITS    (ENTRY_DIGITS),
    .FRACTION_DIGITS (FRACTION_DIGITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .digit     (digit),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // The datapath holds the entry and accumulator, the arithmetic units and
  // the result beat register.
  fcalc_dp #(
    .ENTRY_DIGITS    (ENTRY_DIGITS),
    .FRACTION_DIGITS (FRACTION_DIGITS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .status            (status),
    .accumulator_value (accumulator_value),
    .entry_value       (entry_value),
    .entry_digit_count (entry_digit_count),
    .entry_has_point   (entry_has_point),
    .display_select    (display_select),
    .key_ignored       (key_ignored),
    .overflow          (overflow),
    .divide_by_zero    (divide_by_zero)
  );

endmodule

`default_nettype wire

// ----- sim/four_function_calculator_keypad_test.sv -----
// Self-checking testbench for the four-function calculator keypad.
// Depends on fcalc_pkg and four_function_calculator_keypad; drives key beats and checks results.
`default_nettype none

module four_function_calculator_keypad_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [63:0] acc;
    logic [53:0]        entry;
    logic [3:0]         count;
    logic               point;
    logic [1:0]         show;
    logic               ignored;
    logic               ovf;
    logic               dz;
  } calc_result_t;

  // Scoreboard: holds its own calculator state and the queue of expected results.
  class calc_scoreboard;
    logic signed [63:0] acc;
    logic [63:0]        digits;
    int unsigned        ndig, nfrac;
    bit                 pt, chain;
    logic [2:0]         pend;
    calc_result_t       pending_results[$];
    int                 errors;

    function void clear_all();
      acc = 0; digits = 0; ndig = 0; nfrac = 0; pt = 0; pend = fcalc_pkg::OP_NONE; chain = 0;
    endfunction

    function logic [63:0] pow10(int unsigned n);
      logic [63:0] p;
      p = 1;
      for (int i = 0; i < n; i++) p = p * 10;
      return p;
    endfunction

    function logic [63:0] entry_val();
      logic [63:0] p;
      logic [63:0] lim;
      p = pow10(8 - nfrac);
      lim = (64'd1 << 54) - 1;
      if (digits != 0 && digits > lim / p) return lim;
      return digits * p;
    endfunction

    // Signed magnitude result with saturation into the 64-bit range.
    function logic signed [63:0] to_signed(bit neg, logic [127:0] q, ref bit ovf);
      logic [127:0] limit;
      limit = neg ? (128'd1 << 63) : ((128'd1 << 63) - 1);
      if (q > limit) begin
        ovf = 1;
        return neg ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end
      return neg ? -$signed(q[63:0]) : $signed(q[63:0]);
    endfunction

    function logic signed [63:0] add_sat(logic signed [63:0] a, logic [63:0] e, ref bit ovf);
      logic signed [65:0] s;
      s = $signed({{2{a[63]}}, a}) + $signed({2'b0, e});
      if (s > $signed(66'h0_7FFF_FFFF_FFFF_FFFF)) begin
        ovf = 1;
        return {1'b0, {63{1'b1}}};
      end
      return s[63:0];
    endfunction

    function logic signed [63:0] sub_sat(logic signed [63:0] a, logic [63:0] e, ref bit ovf);
      logic signed [65:0] s;
      s = $signed({{2{a[63]}}, a}) - $signed({2'b0, e});
      if (s < -$signed(66'h0_8000_0000_0000_0000)) begin
        ovf = 1;
        return {1'b1, 63'd0};
      end
      return s[63:0];
    endfunction

    function void apply_op(logic [63:0] e, ref bit ovf, ref bit dz);
      bit neg;
      logic [127:0] mag;
      neg = acc[63];
      mag = neg ? {64'd0, -acc} : {64'd0, acc};
      case (pend)
        fcalc_pkg::OP_ADD: acc = add_sat(acc, e, ovf);
        fcalc_pkg::OP_SUB: acc = sub_sat(acc, e, ovf);
        fcalc_pkg::OP_MUL: acc = to_signed(neg, (mag * e) / 128'd100000000, ovf);
        fcalc_pkg::OP_DIV: begin
          if (e == 0) dz = 1;
          else acc = to_signed(neg, (mag * 128'd100000000) / e, ovf);
        end
        default: ;
      endcase
    endfunction

    function void note_key(logic [2:0] act, logic [3:0] dig);
      calc_result_t r;
      bit ovf, dz, ign;
      logic [63:0] e;
      logic [1:0] show;
      ovf = 0; dz = 0; ign = 0; show = fcalc_pkg::SHOW_ENTRY;
      e = entry_val();
      case (act)
        fcalc_pkg::KEY_DIGIT: begin
          if (dig > 9 || ndig >= 8 || (pt && nfrac >= 8)) ign = 1;
          else begin
            digits = digits * 10 + dig;
            ndig++;
            if (pt) nfrac++;
          end
        end
        fcalc_pkg::KEY_POINT: if (pt) ign = 1; else pt = 1;
        fcalc_pkg::KEY_CLEAR: begin
          acc = 0; digits = 0; ndig = 0; nfrac = 0; pt = 0; show = fcalc_pkg::SHOW_ZERO;
        end
        fcalc_pkg::KEY_EQUALS: begin
          chain = 0;
          apply_op(e, ovf, dz);
          digits = 0; ndig = 0; nfrac = 0; pt = 0; show = fcalc_pkg::SHOW_ACC;
        end
        default: begin
          if (chain) begin
            apply_op(e, ovf, dz);
            show = fcalc_pkg::SHOW_ACC;
          end else begin
            acc = add_sat(acc, e, ovf);
            chain = 1;
            show = fcalc_pkg::SHOW_ZERO;
          end
          pend = act - 3'd2;
          digits = 0; ndig = 0; nfrac = 0; pt = 0;
        end
      endcase
      r.acc = acc; r.entry = 54'(entry_val()); r.count = 4'(ndig); r.point = pt;
      r.show = show; r.ignored = ign; r.ovf = ovf; r.dz = dz;
      pending_results.push_back(r);
    endfunction

    function void check_result(calc_result_t got);
      calc_result_t w;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat, acc %0d", $time, got.acc);
        errors++;
        return;
      end
      w = pending_results.pop_front();
      if (got.acc !== w.acc) begin
        $display("%0t: accumulator expected %0d got %0d", $time, w.acc, got.acc); errors++;
      end
      if (got.entry !== w.entry) begin
        $display("%0t: entry expected %0d got %0d", $time, w.entry, got.entry); errors++;
      end
      if (got.count !== w.count) begin
        $display("%0t: digit count expected %0d got %0d", $time, w.count, got.count); errors++;
      end
      if (got.point !== w.point) begin
        $display("%0t: point expected %0d got %0d", $time, w.point, got.point); errors++;
      end
      if (got.show !== w.show) begin
        $display("%0t: display expected %0d got %0d", $time, w.show, got.show); errors++;
      end
      if (got.ignored !== w.ignored) begin
        $display("%0t: ignored expected %0d got %0d", $time, w.ignored, got.ignored); errors++;
      end
      if (got.ovf !== w.ovf) begin
        $display("%0t: overflow expected %0d got %0d", $time, w.ovf, got.ovf); errors++;
      end
      if (got.dz !== w.dz) begin
        $display("%0t: divide by zero expected %0d got %0d", $time, w.dz, got.dz); errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic [2:0] action = fcalc_pkg::KEY_DIGIT;
  logic [3:0] digit = 0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [63:0] accumulator_value;
  logic [fcalc_pkg::ENTRY_W-1:0] entry_value;
  logic [3:0] entry_digit_count;
  logic entry_has_point;
  logic [1:0] display_select;
  logic key_ignored, overflow, divide_by_zero;

  four_function_calculator_keypad u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .action(action), .digit(digit),
    .out_valid(out_valid), .out_stall(out_stall),
    .accumulator_value(accumulator_value), .entry_value(entry_value),
    .entry_digit_count(entry_digit_count), .entry_has_point(entry_has_point),
    .display_select(display_select), .key_ignored(key_ignored),
    .overflow(overflow), .divide_by_zero(divide_by_zero)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  calc_scoreboard calc_sb = new();

  // Idle percentages for the sender and the receiver, changed per phase.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  longint cycles = 0;

  // Even in the phases with 78% sender gaps or 78% receiver stalls, the run
  // still stays far below the limit.
  localparam longint CYCLE_LIMIT = 4_000_000;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("four_function_calculator_keypad_test: FAIL");
      $finish;
    end
  end

  // Receiver: random stalls, and each accepted result beat goes to the scoreboard.
  always @(posedge clk) begin
    calc_result_t got;
    if (!rst && out_valid && !out_stall) begin
      got.acc = accumulator_value; got.entry = entry_value;
      got.count = entry_digit_count; got.point = entry_has_point;
      got.show = display_select; got.ignored = key_ignored;
      got.ovf = overflow; got.dz = divide_by_zero;
      calc_sb.check_result(got);
    end
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Sends one key beat; idle gaps are drawn before the beat is offered. Valid
  // stays high after acceptance until the next beat or an idle cycle replaces it.
  task automatic send_key(logic [2:0] act, logic [3:0] dig);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    action <= act;
    digit <= dig;
    do @(posedge clk); while (in_stall);
    calc_sb.note_key(act, dig);
  endtask

  task automatic wait_drained();
    in_valid <= 0;
    while (calc_sb.pending_results.size() != 0) @(posedge clk);
  endtask

  // Types a random number: mostly short, sometimes full eight digits or with a point.
  task automatic type_number();
    int n, ppos;
    n = ($urandom_range(9) == 0) ? 8 : $urandom_range(1, 4);
    ppos = ($urandom_range(2) == 0) ? $urandom_range(0, n) : -1;
    for (int i = 0; i < n; i++) begin
      if (i == ppos) send_key(fcalc_pkg::KEY_POINT, 0);
      send_key(fcalc_pkg::KEY_DIGIT, 4'($urandom_range(9)));
    end
  endtask

  task automatic random_phase(int keys);
    int sent;
    sent = 0;
    while (sent < keys) begin
      int pick;
      pick = $urandom_range(99);
      if (pick < 75) begin
        // Well-formed calculation: number, operator, number, ... then equals.
        type_number();
        send_key(3'($urandom_range(fcalc_pkg::KEY_ADD, fcalc_pkg::KEY_DIV)), 0);
        type_number();
        if ($urandom_range(1)) begin
          send_key(3'($urandom_range(fcalc_pkg::KEY_ADD, fcalc_pkg::KEY_DIV)), 0);
          type_number();
        end
        send_key(fcalc_pkg::KEY_EQUALS, 0);
        sent += 12;
      end else begin
        // Noise: any key, any digit code including values above nine.
        send_key(3'($urandom_range(7)), 4'($urandom_range(15)));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed part: entry limits, every operator, overflow and divide by zero.
    for (int i = 0; i < 9; i++) send_key(fcalc_pkg::KEY_DIGIT, 4'd9); // ninth digit dropped
    send_key(fcalc_pkg::KEY_DIGIT, 4'd15);                             // digit above nine
    send_key(fcalc_pkg::KEY_ADD, 0);
    send_key(fcalc_pkg::KEY_POINT, 0);
    send_key(fcalc_pkg::KEY_POINT, 0);                                 // second point
    send_key(fcalc_pkg::KEY_MUL, 0);                                   // lone point is zero
    send_key(fcalc_pkg::KEY_DIGIT, 4'd7);
    send_key(fcalc_pkg::KEY_SUB, 0);
    send_key(fcalc_pkg::KEY_DIV, 0);                                   // divide pending
    send_key(fcalc_pkg::KEY_EQUALS, 0);                                // divide by empty entry
    send_key(fcalc_pkg::KEY_CLEAR, 0);
    send_key(fcalc_pkg::KEY_POINT, 0);
    for (int i = 0; i < 9; i++) send_key(fcalc_pkg::KEY_DIGIT, 4'd1);  // too many fraction digits
    send_key(fcalc_pkg::KEY_DIV, 0);
    send_key(fcalc_pkg::KEY_EQUALS, 0);
    // Grow the accumulator by repeated multiply until it saturates.
    send_key(fcalc_pkg::KEY_CLEAR, 0);
    for (int i = 0; i < 8; i++) send_key(fcalc_pkg::KEY_DIGIT, 4'd9);
    send_key(fcalc_pkg::KEY_MUL, 0);
    for (int k = 0; k < 4; k++) begin
      for (int i = 0; i < 8; i++) send_key(fcalc_pkg::KEY_DIGIT, 4'd9);
      send_key(fcalc_pkg::KEY_MUL, 0);
    end
    send_key(fcalc_pkg::KEY_DIGIT, 4'd8);
    send_key(fcalc_pkg::KEY_ADD, 0);
    send_key(fcalc_pkg::KEY_CLEAR, 0);
    send_key(fcalc_pkg::KEY_SUB, 0);
    for (int i = 0; i < 8; i++) send_key(fcalc_pkg::KEY_DIGIT, 4'd9);
    for (int k = 0; k < 3; k++) send_key(fcalc_pkg::KEY_MUL, 0);
    // Clear, then equals on an empty entry.
    send_key(fcalc_pkg::KEY_CLEAR, 0);
    send_key(fcalc_pkg::KEY_EQUALS, 0);

    // Pause until every expected result has come back.
    wait_drained();

    send_idle_pct = 0;  recv_stall_pct = 0;  random_phase(350);
    send_idle_pct = 78; recv_stall_pct = 0;  random_phase(350);
    wait_drained();
    send_idle_pct = 0;  recv_stall_pct = 78; random_phase(350);
    send_idle_pct = 16; recv_stall_pct = 16; random_phase(350);

    wait_drained();
    recv_stall_pct = 0;
    repeat (600) @(posedge clk);
    if (calc_sb.errors == 0 && calc_sb.pending_results.size() == 0) begin
      $display("four_function_calculator_keypad_test: PASS");
    end else begin
      $display("four_function_calculator_keypad_test: FAIL");
    end
    $finish;
  end
endmodule

`default_nettype wire

// ----- sim.f -----
design/fcalc_pkg.sv
design/fcalc_mul.sv
design/fcalc_div.sv
design/fcalc_dp.sv
design/fcalc_ctrl.sv
design/four_function_calculator_keypad.sv
sim/four_function_calculator_keypad_test.sv
